// File: sv/rhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_pkg
// Shared types, codes and byte classifiers for the request header parser.
// ----------------------------------------------------------------------------
package rhp_pkg;

   localparam int ByteW = 8;
   localparam int AccW  = 32;

   localparam logic [ByteW-1:0] FieldSepReset = 8'd58;
   localparam logic [ByteW-1:0] ListSepReset  = 8'd44;

   localparam logic [ByteW-1:0] ChA     = 8'h41;
   localparam logic [ByteW-1:0] ChU     = 8'h55;
   localparam logic [ByteW-1:0] ChT     = 8'h54;
   localparam logic [ByteW-1:0] ChO     = 8'h4F;
   localparam logic [ByteW-1:0] ChSlash = 8'h2F;
   localparam logic [ByteW-1:0] ChDot   = 8'h2E;
   localparam logic [ByteW-1:0] ChCr    = 8'h0D;
   localparam logic [ByteW-1:0] ChLf    = 8'h0A;
   localparam logic [ByteW-1:0] ChZero  = 8'h30;
   localparam logic [ByteW-1:0] ChNine  = 8'h39;
   localparam logic [ByteW-1:0] CtlMax  = 8'd31;
   localparam logic [ByteW-1:0] DelChar = 8'd127;

   typedef enum logic [1:0] {
      ST_MORE = 2'd0,
      ST_DONE = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_TYPE = 2'd1,
      KIND_ID   = 2'd2
   } kind_type;

   typedef enum logic [4:0] {
      PH_TYPE_START = 5'd0,
      PH_TYPE       = 5'd1,
      PH_ID_START   = 5'd2,
      PH_ID         = 5'd3,
      PH_LIT_A      = 5'd4,
      PH_LIT_U      = 5'd5,
      PH_LIT_T      = 5'd6,
      PH_LIT_O      = 5'd7,
      PH_LIT_SLASH  = 5'd8,
      PH_MAJ_START  = 5'd9,
      PH_MAJ        = 5'd10,
      PH_MIN_START  = 5'd11,
      PH_MIN        = 5'd12,
      PH_LF1        = 5'd13,
      PH_PAR_START  = 5'd14,
      PH_PAR        = 5'd15,
      PH_LF_END     = 5'd16
   } phase_type;

   typedef enum logic {
      CSR_FIELD_SEP = 1'b0,
      CSR_LIST_SEP  = 1'b1
   } csr_index_type;

   typedef struct packed {
      phase_type       phase;
      logic [AccW-1:0] major;
      logic [AccW-1:0] minor;
      logic [AccW-1:0] param;
   } parse_state_type;

   typedef struct packed {
      status_type      status;
      kind_type        name_kind;
      logic            param_done;
      logic [AccW-1:0] param_word;
   } step_result_type;

   function automatic logic is_special(input logic [ByteW-1:0] b);
      logic hit;
      begin
         unique case (b)
            8'h28, 8'h29, 8'h3C, 8'h3E, 8'h40, 8'h2C, 8'h3B, 8'h3A, 8'h5C, 8'h22,
            8'h2F, 8'h5B, 8'h5D, 8'h3F, 8'h3D, 8'h7B, 8'h7D, 8'h20, 8'h09: hit = 1'b1;
            default: hit = 1'b0;
         endcase
         return hit;
      end
   endfunction

   function automatic logic is_name(input logic [ByteW-1:0] b);
      return (b > CtlMax) && (b < DelChar) && !is_special(b);
   endfunction

   function automatic logic is_num(input logic [ByteW-1:0] b);
      return (b >= ChZero) && (b <= ChNine);
   endfunction

   // acc * 10 + digit, wrapping at the accumulator width
   function automatic logic [AccW-1:0] acc10(input logic [AccW-1:0] acc,
                                             input logic [ByteW-1:0] b);
      return (acc << 3) + (acc << 1) + {{(AccW-4){1'b0}}, b[3:0]};
   endfunction

endpackage

// File: sv/rhp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_step
// Next-state and result logic for one byte of request text.
// ----------------------------------------------------------------------------
module rhp_step (
   input  rhp_pkg::parse_state_type cur_state,
   input  logic [rhp_pkg::ByteW-1:0] in_byte,
   input  logic [rhp_pkg::ByteW-1:0] field_sep,
   input  logic [rhp_pkg::ByteW-1:0] list_sep,
   output rhp_pkg::parse_state_type nxt_state,
   output rhp_pkg::step_result_type result
);
   import rhp_pkg::*;

   logic name_ok;
   logic num_ok;

   assign name_ok = is_name(in_byte);
   assign num_ok  = is_num(in_byte);

   always_comb begin
      nxt_state          = cur_state;
      result.status      = ST_BAD;
      result.name_kind   = KIND_NONE;
      result.param_done  = 1'b0;
      result.param_word  = '0;

      unique case (cur_state.phase)
         PH_TYPE_START: begin
            if (name_ok) begin
               nxt_state.phase  = PH_TYPE;
               result.name_kind = KIND_TYPE;
               result.status    = ST_MORE;
            end
         end
         PH_TYPE: begin
            priority if (in_byte == field_sep) begin
               nxt_state.phase = PH_ID_START;
               result.status   = ST_MORE;
            end else if (name_ok) begin
               result.name_kind = KIND_TYPE;
               result.status    = ST_MORE;
            end else begin
               result.status = ST_BAD;
            end
         end
         PH_ID_START: begin
            if (name_ok) begin
               nxt_state.phase  = PH_ID;
               result.name_kind = KIND_ID;
               result.status    = ST_MORE;
            end
         end
         PH_ID: begin
            priority if (in_byte == field_sep) begin
               nxt_state.phase = PH_LIT_A;
               result.status   = ST_MORE;
            end else if (name_ok) begin
               result.name_kind = KIND_ID;
               result.status    = ST_MORE;
            end else begin
               result.status = ST_BAD;
            end
         end
         PH_LIT_A: begin
            if (in_byte == ChA) begin
               nxt_state.phase = PH_LIT_U;
               result.status   = ST_MORE;
            end
         end
         PH_LIT_U: begin
            if (in_byte == ChU) begin
               nxt_state.phase = PH_LIT_T;
               result.status   = ST_MORE;
            end
         end
         PH_LIT_T: begin
            if (in_byte == ChT) begin
               nxt_state.phase = PH_LIT_O;
               result.status   = ST_MORE;
            end
         end
         PH_LIT_O: begin
            if (in_byte == ChO) begin
               nxt_state.phase = PH_LIT_SLASH;
               result.status   = ST_MORE;
            end
         end
         PH_LIT_SLASH: begin
            // clear both version numbers at the start of the version
            if (in_byte == ChSlash) begin
               nxt_state.phase = PH_MAJ_START;
               nxt_state.major = '0;
               nxt_state.minor = '0;
               result.status   = ST_MORE;
            end
         end
         PH_MAJ_START: begin
            if (num_ok) begin
               nxt_state.major = acc10(cur_state.major, in_byte);
               nxt_state.phase = PH_MAJ;
               result.status   = ST_MORE;
            end
         end
         PH_MAJ: begin
            priority if (in_byte == ChDot) begin
               nxt_state.phase = PH_MIN_START;
               result.status   = ST_MORE;
            end else if (num_ok) begin
               nxt_state.major = acc10(cur_state.major, in_byte);
               result.status   = ST_MORE;
            end else begin
               result.status = ST_BAD;
            end
         end
         PH_MIN_START: begin
            if (num_ok) begin
               nxt_state.minor = acc10(cur_state.minor, in_byte);
               nxt_state.phase = PH_MIN;
               result.status   = ST_MORE;
            end
         end
         PH_MIN: begin
            priority if (in_byte == ChCr) begin
               nxt_state.phase = PH_LF1;
               result.status   = ST_MORE;
            end else if (num_ok) begin
               nxt_state.minor = acc10(cur_state.minor, in_byte);
               result.status   = ST_MORE;
            end else begin
               result.status = ST_BAD;
            end
         end
         PH_LF1: begin
            if (in_byte == ChLf) begin
               nxt_state.phase = PH_PAR_START;
               result.status   = ST_MORE;
            end
         end
         PH_PAR_START: begin
            priority if (in_byte == ChCr) begin
               nxt_state.phase = PH_LF_END;
               result.status   = ST_MORE;
            end else if (num_ok) begin
               nxt_state.param = {{(AccW-4){1'b0}}, in_byte[3:0]};
               nxt_state.phase = PH_PAR;
               result.status   = ST_MORE;
            end else begin
               result.status = ST_BAD;
            end
         end
         PH_PAR: begin
            // list separator wins over CR and digits
            priority if (in_byte == list_sep) begin
               nxt_state.phase    = PH_PAR_START;
               result.param_done  = 1'b1;
               result.param_word  = cur_state.param;
               result.status      = ST_MORE;
            end else if (in_byte == ChCr) begin
               nxt_state.phase    = PH_LF_END;
               result.param_done  = 1'b1;
               result.param_word  = cur_state.param;
               result.status      = ST_MORE;
            end else if (num_ok) begin
               nxt_state.param = acc10(cur_state.param, in_byte);
               result.status   = ST_MORE;
            end else begin
               result.status = ST_BAD;
            end
         end
         PH_LF_END: begin
            result.status = (in_byte == ChLf) ? ST_DONE : ST_BAD;
         end
         default: begin
            result.status = ST_BAD;
         end
      endcase
   end

endmodule

// File: sv/request_header_parser_core.sv
`timescale 1ns / 1ps
// A req_ byte reaches its rsp_ beat through the input register, then the result register.
// Throughput: one byte per cycle unless rsp_ stalls; state and accumulators update per byte.
// A stalled rsp_ side holds one result while one more byte waits in the input register.
// Reset (synchronous, active high) returns to the type start phase, zeroes the accumulators,
// restores the separators to ':' and ',' and empties both registers.
// ----------------------------------------------------------------------------
// request_header_parser_core
// Byte-at-a-time request header parser with valid/ready channels.
// ----------------------------------------------------------------------------
module request_header_parser_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic                             csr_index,
   input  logic [rhp_pkg::ByteW-1:0]        csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rhp_pkg::ByteW-1:0]        req_in_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [1:0]                       rsp_status,
   output logic [1:0]                       rsp_name_kind,
   output logic                             rsp_param_done,
   output logic [rhp_pkg::AccW-1:0]         rsp_param_word,
   output logic [rhp_pkg::AccW-1:0]         rsp_ver_major,
   output logic [rhp_pkg::AccW-1:0]         rsp_version_minor
);
   import rhp_pkg::*;

   logic                in_valid_ff, in_valid_in;
   logic [ByteW-1:0]    in_byte_ff,  in_byte_in;
   logic                out_valid_ff, out_valid_in;
   step_result_type     out_res_ff,  out_res_in;
   logic [AccW-1:0]     out_major_ff, out_major_in;
   logic [AccW-1:0]     out_minor_ff, out_minor_in;
   parse_state_type     state_ff,    state_in;
   logic [ByteW-1:0]    field_sep_ff, field_sep_in;
   logic [ByteW-1:0]    list_sep_ff,  list_sep_in;

   parse_state_type     step_state;
   step_result_type     step_res;
   logic                advance;
   logic                req_take;

   rhp_step u_step (
      .cur_state (state_ff),
      .in_byte   (in_byte_ff),
      .field_sep (field_sep_ff),
      .list_sep  (list_sep_ff),
      .nxt_state (step_state),
      .result    (step_res)
   );

   // move a byte into the result register when that register is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      out_major_in = out_major_ff;
      out_minor_in = out_minor_ff;
      state_in     = state_ff;
      field_sep_in = field_sep_ff;
      list_sep_in  = list_sep_ff;

      if (advance) begin
         in_valid_in  = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end

      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_res_in   = step_res;
         out_major_in = step_state.major;
         out_minor_in = step_state.minor;
         state_in     = step_state;
      end

      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_FIELD_SEP: field_sep_in = csr_wdata;
            CSR_LIST_SEP:  list_sep_in  = csr_wdata;
            default:       field_sep_in = field_sep_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         state_ff.phase <= PH_TYPE_START;
         state_ff.major <= '0;
         state_ff.minor <= '0;
         state_ff.param <= '0;
         field_sep_ff   <= FieldSepReset;
         list_sep_ff    <= ListSepReset;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         field_sep_ff <= field_sep_in;
         list_sep_ff  <= list_sep_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      out_res_ff   <= out_res_in;
      out_major_ff <= out_major_in;
      out_minor_ff <= out_minor_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_res_ff.status;
   assign rsp_name_kind     = out_res_ff.name_kind;
   assign rsp_param_done    = out_res_ff.param_done;
   assign rsp_param_word    = out_res_ff.param_word;
   assign rsp_ver_major     = out_major_ff;
   assign rsp_version_minor = out_minor_ff;

endmodule

// File: sv/rhp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhp_checker
// Port-level checks on the request header parser, bound to the top level.
// ----------------------------------------------------------------------------
module rhp_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [1:0]                 rsp_status,
   input logic [1:0]                 rsp_name_kind,
   input logic                       rsp_param_done,
   input logic [rhp_pkg::AccW-1:0]   rsp_param_word
);
   import rhp_pkg::*;

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_param_word))
      else $error("stalled result beat changed");

   // nothing comes out right after reset
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   // parameter word is zero unless a parameter finished
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_param_done |-> rsp_param_word == '0)
      else $error("param word without param_done");

   // name tags and finished parameters only come with status more
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_name_kind != KIND_NONE || rsp_param_done) |->
         rsp_status == ST_MORE)
      else $error("tagged beat with terminal status");

   // with the result side free behind it, an accepted byte moves on from the input register to a result beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 (!rsp_valid || rsp_ready) |=> rsp_valid)
      else $error("accepted byte did not produce a result");

endmodule

bind request_header_parser_core rhp_checker u_rhp_checker (.*);
